>>> sv/krb_pkg.sv
// ----------------------------------------------------------------------------
// krb_pkg
// Shared types and constants for the keyboard rollover report builder.
// ----------------------------------------------------------------------------
package krb_pkg;

    // event modes on the input stream
    localparam logic [2:0] MODE_KEY_PRESS     = 3'd0;
    localparam logic [2:0] MODE_KEY_RELEASE   = 3'd1;
    localparam logic [2:0] MODE_MOD_PRESS     = 3'd2;
    localparam logic [2:0] MODE_MOD_RELEASE   = 3'd3;
    localparam logic [2:0] MODE_SHIFT_PRESS   = 3'd4;
    localparam logic [2:0] MODE_SHIFT_RELEASE = 3'd5;
    localparam logic [2:0] MODE_SET_MODS      = 3'd6;
    localparam logic [2:0] MODE_RELEASE_ALL   = 3'd7;

    // result item kinds
    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_BOOT   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam int unsigned KEY_OFFSET = 136;
    localparam int unsigned KEY_LIMIT  = 6;
    localparam int unsigned BOOT_SLOTS = 6;
    localparam int unsigned MAX_ITEMS  = 4;

    // configuration register addresses (byte address bit 2 selects register)
    localparam logic REG_FULL_ROLLOVER = 1'b0;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_PRESS,
        ACT_RELEASE,
        ACT_MOD_SET,
        ACT_MOD_CLR,
        ACT_MOD_LOAD,
        ACT_CLEAR_ALL
    } act_t;

    // classified event, front to back
    typedef struct packed {
        act_t       act1;
        logic       rep1;
        act_t       act2;
        logic       rep2;
        logic       reject;
        logic [7:0] key;
        logic [7:0] mod_val;
        logic       link;
    } cmd_t;

    typedef struct packed {
        logic                       accepted;
        logic [1:0]                 item_kind;
        logic [7:0]                 modifier_bits;
        logic                       word_index;
        logic [63:0]                bitmap_word;
        logic [BOOT_SLOTS-1:0][7:0] slots;
        logic                       last_item;
    } item_t;

endpackage

>>> sv/krb_front.sv
// ----------------------------------------------------------------------------
// krb_front
// Accepts keyboard events and classifies them into one or two actions.
// ----------------------------------------------------------------------------
module krb_front (
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [24:0]   s_fields,   // key_code[7:0], mod_value[23:8], link_up[24]
    input  logic [2:0]    s_mode,
    input  logic          q_full,
    output logic          q_push,
    output krb_pkg::cmd_t cmd
);
    import krb_pkg::*;

    logic [7:0]  raw_key;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic        hi_onehot;
    logic        mv_ok;

    assign raw_key   = s_fields[7:0];
    assign lo        = s_fields[15:8];
    assign hi        = s_fields[23:16];
    assign hi_onehot = (hi != 8'd0) && ((hi & (hi - 8'd1)) == 8'd0);
    assign mv_ok     = hi_onehot && (lo == 8'd0);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        cmd         = '0;
        cmd.act1    = ACT_NONE;
        cmd.act2    = ACT_NONE;
        cmd.key     = (raw_key >= 8'(KEY_OFFSET)) ? raw_key - 8'(KEY_OFFSET) : raw_key;
        cmd.mod_val = hi;
        cmd.link    = s_fields[24];
        case (s_mode)
            MODE_KEY_PRESS: begin
                cmd.act1 = ACT_PRESS;
                cmd.rep1 = 1'b1;
            end
            MODE_KEY_RELEASE: begin
                cmd.act1 = ACT_RELEASE;
                cmd.rep1 = 1'b1;
            end
            MODE_MOD_PRESS: begin
                cmd.act1   = mv_ok ? ACT_MOD_SET : ACT_NONE;
                cmd.rep1   = mv_ok;
                cmd.reject = !mv_ok;
            end
            MODE_MOD_RELEASE: begin
                cmd.act1   = mv_ok ? ACT_MOD_CLR : ACT_NONE;
                cmd.rep1   = mv_ok;
                cmd.reject = !mv_ok;
            end
            MODE_SHIFT_PRESS: begin
                // invalid modifier byte is skipped without a report
                cmd.act1 = hi_onehot ? ACT_MOD_SET : ACT_NONE;
                cmd.rep1 = hi_onehot;
                cmd.act2 = ACT_PRESS;
                cmd.rep2 = 1'b1;
            end
            MODE_SHIFT_RELEASE: begin
                cmd.act1 = ACT_RELEASE;
                cmd.rep1 = 1'b1;
                cmd.act2 = hi_onehot ? ACT_MOD_CLR : ACT_NONE;
                cmd.rep2 = hi_onehot;
            end
            MODE_SET_MODS: begin
                cmd.act1 = ACT_MOD_LOAD;
                cmd.rep1 = 1'b1;
            end
            default: begin
                cmd.act1 = ACT_CLEAR_ALL;
                cmd.rep1 = 1'b1;
            end
        endcase
    end

endmodule

>>> sv/krb_fifo.sv
// ----------------------------------------------------------------------------
// krb_fifo
// Short command queue between the event front and the report sequencer.
// ----------------------------------------------------------------------------
module krb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

>>> sv/krb_back.sv
// ----------------------------------------------------------------------------
// krb_back
// Report sequencer: applies actions to the key map and modifier byte, scans
// the boot slots and drives the result register.
// ----------------------------------------------------------------------------
module krb_back #(
    parameter int KEY_SLOTS = 128
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           full_rollover,
    input  krb_pkg::cmd_t  q_cmd,
    input  logic           q_valid,
    output logic           q_pop,
    output krb_pkg::item_t item,
    output logic           m_valid,
    input  logic           m_ready
);
    import krb_pkg::*;

    localparam int MAP_WORDS = (KEY_SLOTS + 63) / 64;
    localparam int MAP_BITS  = MAP_WORDS * 64;
    localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int KI        = $clog2(MAP_BITS);
    localparam int CW        = $clog2(KEY_SLOTS + 1);
    localparam logic [WW-1:0] LAST_WORD = WW'(MAP_WORDS - 1);
    // two full reports in one event fit only while both stay within the item cap
    localparam logic FIT_TWO = (2 * MAP_WORDS <= MAX_ITEMS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN,
        ST_EMIT,
        ST_STATUS
    } state_t;

    state_t                     state_reg;
    logic                       phase_reg;
    logic [MAP_BITS-1:0]        map_reg;
    logic [7:0]                 held_reg;
    logic [CW-1:0]              count_reg;
    cmd_t                       cmd_reg;
    act_t                       act1_reg;
    act_t                       act2_reg;
    logic                       emit1_reg;
    logic                       emit2_reg;
    logic                       acc_reg;
    logic [WW-1:0]              word_reg;
    logic                       loaded_reg;
    logic [63:0]                scan_reg;
    logic [2:0]                 slot_cnt_reg;
    logic [BOOT_SLOTS-1:0][7:0] slots_reg;
    logic                       m_valid_reg;
    item_t                      item_reg;

    logic        press_ok;
    logic        r1;
    logic        r2;
    logic        drop;
    act_t        cur_act;
    logic        cur_emit;
    logic        report_last;
    logic        key_hit;
    logic [KI-1:0] kidx;
    logic        key_bit;
    logic [63:0] cur_word;
    logic        out_free;
    logic        emit_now;
    state_t      after_phase;

    function automatic logic [5:0] lowest_one(input logic [63:0] v);
        logic [5:0] idx;
        idx = '0;
        for (int i = 63; i >= 0; i--) begin
            if (v[i]) idx = 6'(i);
        end
        return idx;
    endfunction

    // dispatch decisions, taken on the queue head
    assign press_ok = full_rollover || (q_cmd.key == 8'd0) || (count_reg < CW'(KEY_LIMIT));
    assign r1       = q_cmd.rep1 && !((q_cmd.act1 == ACT_PRESS) && !press_ok);
    assign r2       = q_cmd.rep2 && !((q_cmd.act2 == ACT_PRESS) && !press_ok);
    assign drop     = full_rollover && !FIT_TWO && r1 && r2;

    assign cur_act     = phase_reg ? act2_reg : act1_reg;
    assign cur_emit    = phase_reg ? emit2_reg : emit1_reg;
    assign report_last = phase_reg || !emit2_reg;
    assign after_phase = !phase_reg ? ST_APPLY
                       : ((emit1_reg || emit2_reg) ? ST_IDLE : ST_STATUS);

    assign key_hit  = (cmd_reg.key != 8'd0) && ({1'b0, cmd_reg.key} < 9'(KEY_SLOTS));
    assign kidx     = cmd_reg.key[KI-1:0];
    assign key_bit  = map_reg[kidx];
    assign cur_word = map_reg[{word_reg, 6'd0} +: 64];
    assign out_free = !m_valid_reg || m_ready;
    assign emit_now = out_free && ((state_reg == ST_EMIT) || (state_reg == ST_STATUS));

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = m_valid_reg;
    assign item    = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            map_reg     <= '0;
            held_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        cmd_reg   <= q_cmd;
                        act1_reg  <= ((q_cmd.act1 == ACT_PRESS) && !press_ok) ? ACT_NONE
                                                                               : q_cmd.act1;
                        act2_reg  <= ((q_cmd.act2 == ACT_PRESS) && !press_ok) ? ACT_NONE
                                                                               : q_cmd.act2;
                        emit1_reg <= q_cmd.link && r1 && !drop;
                        emit2_reg <= q_cmd.link && r2;
                        acc_reg   <= !q_cmd.reject && !(!press_ok &&
                                     ((q_cmd.act1 == ACT_PRESS) || (q_cmd.act2 == ACT_PRESS)));
                        phase_reg <= 1'b0;
                        state_reg <= ST_APPLY;
                    end
                end
                ST_APPLY: begin
                    case (cur_act)
                        ACT_PRESS: begin
                            if (key_hit) begin
                                map_reg[kidx] <= 1'b1;
                                if (!key_bit) count_reg <= count_reg + CW'(1);
                            end
                        end
                        ACT_RELEASE: begin
                            if (key_hit) begin
                                map_reg[kidx] <= 1'b0;
                                if (key_bit) count_reg <= count_reg - CW'(1);
                            end
                        end
                        ACT_MOD_SET:  held_reg <= held_reg | cmd_reg.mod_val;
                        ACT_MOD_CLR:  held_reg <= held_reg & ~cmd_reg.mod_val;
                        ACT_MOD_LOAD: held_reg <= cmd_reg.mod_val;
                        ACT_CLEAR_ALL: begin
                            map_reg   <= '0;
                            held_reg  <= '0;
                            count_reg <= '0;
                        end
                        default: ;
                    endcase
                    if (cur_emit) begin
                        word_reg <= '0;
                        if (full_rollover) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            loaded_reg   <= 1'b0;
                            slot_cnt_reg <= '0;
                            slots_reg    <= '0;
                            state_reg    <= ST_SCAN;
                        end
                    end else begin
                        phase_reg <= 1'b1;
                        state_reg <= after_phase;
                    end
                end
                ST_SCAN: begin
                    // one lowest set key per cycle, word by word
                    if (!loaded_reg) begin
                        scan_reg   <= cur_word;
                        loaded_reg <= 1'b1;
                    end else if ((slot_cnt_reg == 3'(BOOT_SLOTS)) || (scan_reg == 64'd0)) begin
                        if ((slot_cnt_reg == 3'(BOOT_SLOTS)) || (word_reg == LAST_WORD)) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            word_reg   <= word_reg + WW'(1);
                            loaded_reg <= 1'b0;
                        end
                    end else begin
                        slots_reg[slot_cnt_reg] <= 8'({word_reg, lowest_one(scan_reg)});
                        scan_reg     <= scan_reg & (scan_reg - 64'd1);
                        slot_cnt_reg <= slot_cnt_reg + 3'd1;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        item_reg.accepted      <= acc_reg;
                        item_reg.modifier_bits <= held_reg;
                        if (full_rollover) begin
                            item_reg.item_kind   <= KIND_WORD;
                            item_reg.word_index  <= word_reg[0];
                            item_reg.bitmap_word <= cur_word;
                            item_reg.slots       <= '0;
                            item_reg.last_item   <= (word_reg == LAST_WORD) && report_last;
                            if (word_reg == LAST_WORD) begin
                                phase_reg <= 1'b1;
                                state_reg <= after_phase;
                            end else begin
                                word_reg <= word_reg + WW'(1);
                            end
                        end else begin
                            item_reg.item_kind   <= KIND_BOOT;
                            item_reg.word_index  <= 1'b0;
                            item_reg.bitmap_word <= '0;
                            item_reg.slots       <= slots_reg;
                            item_reg.last_item   <= report_last;
                            phase_reg <= 1'b1;
                            state_reg <= after_phase;
                        end
                    end
                end
                ST_STATUS: begin
                    if (out_free) begin
                        item_reg.accepted      <= acc_reg;
                        item_reg.item_kind     <= KIND_STATUS;
                        item_reg.modifier_bits <= held_reg;
                        item_reg.word_index    <= 1'b0;
                        item_reg.bitmap_word   <= '0;
                        item_reg.slots         <= '0;
                        item_reg.last_item     <= 1'b1;
                        state_reg              <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> sv/keyboard_rollover_report_builder.sv
// ----------------------------------------------------------------------------
// keyboard_rollover_report_builder
// Keeps a pressed-key bitmap and modifier byte from keyboard events and
// streams full bitmap reports or six-key boot reports.
//
//  channel  dir  width          contents
//  s_       in   tdata32/tuser3 key event (key_code, mod_value, link_up; mode)
//  m_       out  tdata128/tuser2 report item (fields; item_kind), tlast
//  apb      in   32-bit data    register 0: full_rollover
//
// Per event: a dispatch step, then one apply step per action slot, each with its
// report if any; a full report gives one item per 64-bit map word, a boot report a
// slot scan plus one item; an event without report adds one status item.
// Reset clears the key map, modifiers and key count; full_rollover resets to 1.
// The front keeps accepting events into a QUEUE_DEPTH command queue while the
// sequencer is busy or m_tready is low; a low m_tready holds the sequencer.
// ----------------------------------------------------------------------------
module keyboard_rollover_report_builder #(
    parameter int KEY_SLOTS   = 128,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    // event input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // key_code[7:0], mod_value[23:8], link_up[24]
    input  logic [2:0]   s_tuser,   // mode[2:0]
    // report output
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // accepted[0], modifier_bits[8:1], word_index[9],
                                    // bitmap_word[73:10], slot_zero[81:74],
                                    // slot_one[89:82], slot_two[97:90],
                                    // slot_three[105:98], slot_four[113:106],
                                    // slot_five[121:114]
    output logic [1:0]   m_tuser,   // item_kind[1:0]
    output logic         m_tlast,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import krb_pkg::*;

    logic  full_rollover_reg;
    cmd_t  front_cmd;
    cmd_t  q_cmd;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_valid;
    item_t item;

    // register file
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FULL_ROLLOVER) ? {31'd0, full_rollover_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_rollover_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == REG_FULL_ROLLOVER)) begin
            full_rollover_reg <= pwdata[0];
        end
    end

    krb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_fields (s_tdata[24:0]),
        .s_mode   (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .cmd      (front_cmd)
    );

    krb_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_cmd),
        .pop       (q_pop),
        .pop_data  (q_cmd),
        .full      (q_full),
        .not_empty (q_valid)
    );

    krb_back #(
        .KEY_SLOTS (KEY_SLOTS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .full_rollover (full_rollover_reg),
        .q_cmd         (q_cmd),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .item          (item),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready)
    );

    assign m_tdata = {6'd0, item.slots, item.bitmap_word, item.word_index,
                      item.modifier_bits, item.accepted};
    assign m_tuser = item.item_kind;
    assign m_tlast = item.last_item;

endmodule

>>> sv/krb_checker.sv
// ----------------------------------------------------------------------------
// krb_checker
// Port-level checks on the report stream of the rollover report builder.
// ----------------------------------------------------------------------------
module krb_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);
    import krb_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a status item closes its event
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_STATUS) |-> m_tlast)
        else $error("status item not last");

    a_nonword_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_WORD) |-> (m_tdata[73:9] == 65'd0))
        else $error("bitmap fields set outside a word item");

    a_word_slots_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_WORD) |-> (m_tdata[121:74] == 48'd0))
        else $error("boot slots set in a word item");

endmodule

bind keyboard_rollover_report_builder krb_checker u_krb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> bench/tb_keyboard_rollover_report_builder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyboard_rollover_report_builder
// Self-checking bench for the keyboard rollover report builder. Key events are
// streamed in under several idle and backpressure patterns, in both rollover
// modes. Report items are compared field by field against an in-bench model of
// the key map, modifier byte and report format, or a directed row's expectation.
// ----------------------------------------------------------------------------
module tb_keyboard_rollover_report_builder;
    import krb_pkg::*;

    localparam int          MAP_KEYS      = 128;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          DIR_ROWS      = 29;
    localparam logic [2:0]  ROLLOVER_ADDR = {REG_FULL_ROLLOVER, 2'b00};

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  key;
        logic [15:0] modv;
        logic        link;
    } key_event_t;

    typedef struct packed {
        key_event_t ev;
        logic       full;
        logic       typed;     // expectation given below instead of the model
        logic       typed_acc; // single status item, modifiers zero
    } dir_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic [2:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    keyboard_rollover_report_builder #(.KEY_SLOTS(MAP_KEYS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 aclk = ~aclk;

    // model state
    bit [MAP_KEYS-1:0] key_map;
    logic [7:0]        held_mods;
    bit                full_mode;
    item_t             step_out[$];
    item_t             pending_reports[$];

    int err_count     = 0;
    int events_sent   = 0;
    int items_checked = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int rx_hold       = 0;

    dir_row_t dir_rows [DIR_ROWS];

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            $display("MISMATCH item %0d %s: got %0h want %0h", items_checked, name, got, want);
            err_count++;
        end
    endtask

    // ---------------- report model ----------------
    function automatic logic [7:0] fold_code(input logic [7:0] raw);
        return (raw >= KEY_OFFSET) ? raw - KEY_OFFSET[7:0] : raw;
    endfunction

    task automatic emit_report(input logic link);
        item_t it;
        int    need;
        int    slot;
        if (!link) return;
        need = full_mode ? 2 : 1;
        if (step_out.size() + need > MAX_ITEMS) step_out.delete();
        if (full_mode) begin
            for (int w = 0; w < 2; w++) begin
                it = '0;
                it.item_kind     = KIND_WORD;
                it.modifier_bits = held_mods;
                it.word_index    = w[0];
                it.bitmap_word   = key_map[64*w +: 64];
                step_out.push_back(it);
            end
        end else begin
            it = '0;
            it.item_kind     = KIND_BOOT;
            it.modifier_bits = held_mods;
            slot = 0;
            for (int i = 0; i < MAP_KEYS && slot < BOOT_SLOTS; i++) begin
                if (key_map[i]) begin
                    it.slots[slot] = i[7:0];
                    slot++;
                end
            end
            step_out.push_back(it);
        end
    endtask

    task automatic press_key(input logic [7:0] raw, input logic link, output bit ok);
        logic [7:0] k;
        k  = fold_code(raw);
        ok = 1'b1;
        if (k != 0) begin
            // limit check applies even to keys already down or off the map
            if (!full_mode && $countones(key_map) >= KEY_LIMIT) begin
                ok = 1'b0;
                return;
            end
            if (k < MAP_KEYS) key_map[k] = 1'b1;
        end
        emit_report(link);
    endtask

    task automatic release_key(input logic [7:0] raw, input logic link);
        logic [7:0] k;
        k = fold_code(raw);
        if (k != 0 && k < MAP_KEYS) key_map[k] = 1'b0;
        emit_report(link);
    endtask

    task automatic change_mods(input logic [15:0] v, input bit on, input logic link,
                               output bit ok);
        ok = $onehot(v) && (v[7:0] == 8'h00);
        if (!ok) return;
        if (on) held_mods = held_mods | v[15:8];
        else    held_mods = held_mods & ~v[15:8];
        emit_report(link);
    endtask

    task automatic model_event(input key_event_t ev);
        bit         ok;
        bit         dummy;
        logic [7:0] hi;
        item_t      it;
        step_out.delete();
        ok = 1'b1;
        hi = ev.modv[15:8];
        case (ev.mode)
            MODE_KEY_PRESS:   press_key(ev.key, ev.link, ok);
            MODE_KEY_RELEASE: release_key(ev.key, ev.link);
            MODE_MOD_PRESS:   change_mods(ev.modv, 1'b1, ev.link, ok);
            MODE_MOD_RELEASE: change_mods(ev.modv, 1'b0, ev.link, ok);
            MODE_SHIFT_PRESS: begin
                if (hi != 0) change_mods({hi, 8'h00}, 1'b1, ev.link, dummy);
                press_key(ev.key, ev.link, ok);
            end
            MODE_SHIFT_RELEASE: begin
                release_key(ev.key, ev.link);
                if (hi != 0) change_mods({hi, 8'h00}, 1'b0, ev.link, dummy);
            end
            MODE_SET_MODS: begin
                held_mods = hi;
                emit_report(ev.link);
            end
            default: begin
                key_map   = '0;
                held_mods = 8'h00;
                emit_report(ev.link);
            end
        endcase
        if (step_out.size() == 0) begin
            it = '0;
            it.item_kind     = KIND_STATUS;
            it.modifier_bits = held_mods;
            step_out.push_back(it);
        end
        for (int i = 0; i < step_out.size(); i++) begin
            it = step_out[i];
            it.accepted  = ok;
            it.last_item = (i == step_out.size() - 1);
            step_out[i]  = it;
        end
    endtask

    // ---------------- stimulus ----------------
    task automatic push_event(input key_event_t ev, input bit typed, input logic typed_acc);
        item_t it;
        @(negedge aclk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {7'b0, ev.link, ev.modv, ev.key};
        s_tuser  = ev.mode;
        do @(posedge aclk); while (!s_tready);
        model_event(ev);
        events_sent++;
        if (typed) begin
            it = '0;
            it.accepted  = typed_acc;
            it.item_kind = KIND_STATUS;
            it.last_item = 1'b1;
            pending_reports.push_back(it);
        end else begin
            foreach (step_out[i]) pending_reports.push_back(step_out[i]);
        end
    endtask

    function automatic key_event_t make_random_event();
        key_event_t ev;
        int         r;
        r = $urandom_range(0, 99);
        ev.mode = (r < 30) ? MODE_KEY_PRESS   :
                  (r < 50) ? MODE_KEY_RELEASE :
                  (r < 60) ? MODE_MOD_PRESS   :
                  (r < 68) ? MODE_MOD_RELEASE :
                  (r < 78) ? MODE_SHIFT_PRESS :
                  (r < 86) ? MODE_SHIFT_RELEASE :
                  (r < 92) ? MODE_SET_MODS    : MODE_RELEASE_ALL;
        // small pool so releases hit held keys; folded codes and full range too
        r = $urandom_range(0, 99);
        if (r < 65)      ev.key = 8'($urandom_range(0, 15));
        else if (r < 80) ev.key = 8'(KEY_OFFSET + $urandom_range(0, 15));
        else             ev.key = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 60)      ev.modv = 16'h0100 << $urandom_range(0, 7);
        else if (r < 75) ev.modv = 16'($urandom_range(0, 255));
        else             ev.modv = 16'($urandom_range(0, 65535));
        ev.link = ($urandom_range(0, 99) < 90);
        return ev;
    endfunction

    // ---------------- configuration ----------------
    task automatic write_rollover(input logic v);
        logic [31:0] rd;
        @(negedge aclk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = ROLLOVER_ADDR; pwdata = {31'b0, v};
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        full_mode = v;
        @(negedge aclk);
        penable = 1'b0; pwrite = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0;
        check_field("full_rollover readback", rd, {31'b0, v});
    endtask

    task automatic settle();
        // drop the last request before waiting so it is not taken again
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------- result checking ----------------
    initial begin
        item_t got;
        item_t want;
        forever begin
            @(negedge aclk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                got.accepted      = m_tdata[0];
                got.modifier_bits = m_tdata[8:1];
                got.word_index    = m_tdata[9];
                got.bitmap_word   = m_tdata[73:10];
                for (int i = 0; i < BOOT_SLOTS; i++) got.slots[i] = m_tdata[74 + 8*i +: 8];
                got.item_kind     = m_tuser;
                got.last_item     = m_tlast;
                if (pending_reports.size() == 0) begin
                    check_field("unexpected item, kind", got.item_kind, 64'hx);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("accepted", got.accepted, want.accepted);
                    check_field("item_kind", got.item_kind, want.item_kind);
                    check_field("modifier_bits", got.modifier_bits, want.modifier_bits);
                    check_field("word_index", got.word_index, want.word_index);
                    check_field("bitmap_word", got.bitmap_word, want.bitmap_word);
                    for (int i = 0; i < BOOT_SLOTS; i++)
                        check_field($sformatf("slot %0d", i), got.slots[i], want.slots[i]);
                    check_field("last_item", got.last_item, want.last_item);
                end
                items_checked++;
            end
        end
    end

    // ---------------- run ----------------
    initial begin
        int  tx_pct [4];
        int  rx_pct [4];
        bit  mode_of[4];
        tx_pct  = '{0, 52, 0, 9};
        rx_pct  = '{0, 0, 52, 9};
        mode_of = '{1'b1, 1'b0, 1'b0, 1'b1};
        dir_rows = '{
            '{'{MODE_KEY_PRESS,     8'd0,   16'h0000, 1'b0}, 1'b1, 1'b1, 1'b1}, // link down
            '{'{MODE_MOD_PRESS,     8'd0,   16'h0101, 1'b1}, 1'b1, 1'b1, 1'b0}, // low byte set
            '{'{MODE_MOD_PRESS,     8'd0,   16'h0300, 1'b1}, 1'b1, 1'b1, 1'b0}, // two bits
            '{'{MODE_MOD_RELEASE,   8'd0,   16'h0000, 1'b1}, 1'b1, 1'b1, 1'b0}, // no bit
            '{'{MODE_MOD_PRESS,     8'd0,   16'h8000, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_MOD_PRESS,     8'd0,   16'h0100, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd4,   16'h0000, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd127, 16'h0000, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd128, 16'h0000, 1'b1}, 1'b1, 1'b0, 1'b0}, // off the map
            '{'{MODE_KEY_PRESS,     8'd136, 16'h0000, 1'b1}, 1'b1, 1'b0, 1'b0}, // folds to zero
            '{'{MODE_KEY_PRESS,     8'd255, 16'h0000, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_SHIFT_PRESS,   8'd5,   16'h0200, 1'b1}, 1'b1, 1'b0, 1'b0}, // two reports
            '{'{MODE_SHIFT_PRESS,   8'd6,   16'h0300, 1'b1}, 1'b1, 1'b0, 1'b0}, // bad mod skipped
            '{'{MODE_SHIFT_RELEASE, 8'd5,   16'h0200, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_SHIFT_RELEASE, 8'd6,   16'hFFFF, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_KEY_RELEASE,   8'd127, 16'h0000, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_SET_MODS,      8'd0,   16'hA5FF, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd63,  16'h0000, 1'b0}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_RELEASE_ALL,   8'd0,   16'h0000, 1'b1}, 1'b1, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd1,   16'h0000, 1'b1}, 1'b0, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd2,   16'h0000, 1'b1}, 1'b0, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd3,   16'h0000, 1'b1}, 1'b0, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd70,  16'h0000, 1'b1}, 1'b0, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd100, 16'h0000, 1'b1}, 1'b0, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd64,  16'h0000, 1'b1}, 1'b0, 1'b0, 1'b0},
            '{'{MODE_KEY_PRESS,     8'd7,   16'h0000, 1'b1}, 1'b0, 1'b1, 1'b0}, // over limit
            '{'{MODE_KEY_PRESS,     8'd0,   16'h0000, 1'b1}, 1'b0, 1'b0, 1'b0},
            '{'{MODE_SHIFT_PRESS,   8'd9,   16'h0100, 1'b1}, 1'b0, 1'b0, 1'b0},
            '{'{MODE_RELEASE_ALL,   8'd0,   16'h0000, 1'b1}, 1'b0, 1'b0, 1'b0}
        };
        key_map   = '0;
        held_mods = 8'h00;
        full_mode = 1'b1;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].full != full_mode) begin
                settle();
                write_rollover(dir_rows[r].full);
            end
            push_event(dir_rows[r].ev, dir_rows[r].typed, dir_rows[r].typed_acc);
        end

        for (int p = 0; p < 4; p++) begin
            settle();
            write_rollover(mode_of[p]);
            tx_idle_pct  = tx_pct[p];
            rx_stall_pct = rx_pct[p];
            repeat (22) push_event(make_random_event(), 1'b0, 1'b0);
        end

        // long receiver hold-off while the sender keeps pushing
        settle();
        write_rollover(1'b1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(posedge aclk);
        rx_hold = 300;
        repeat (16) push_event(make_random_event(), 1'b0, 1'b0);
        @(negedge aclk);
        s_tvalid = 1'b0;

        settle();
        $display("Covered %0d key events and %0d report items in both rollover modes,",
                 events_sent, items_checked);
        $display("with sender gaps, receiver stalls and a long output hold-off.");
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("Timeout with %0d items outstanding", pending_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
